// ===== sv/stbs_pkg.sv =====
// ----------------------------------------------------------------------------
// stbs_pkg
// Shared types and constants for the sorted breakpoint table bracket search.
// ----------------------------------------------------------------------------
package stbs_pkg;

  localparam int VALUE_W   = 32;
  localparam int IDX_W     = 6;
  localparam int CNT_W     = 7;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = CNT_W;

  // item opcodes
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ENTRIES   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OVERRANGE = 1'd1;

  typedef struct packed {
    logic                      op;
    logic [IDX_W-1:0]          entry_index;
    logic signed [VALUE_W-1:0] value;
  } stbs_in_t;

  typedef struct packed {
    logic                      found;
    logic signed [VALUE_W-1:0] lower_value;
    logic signed [VALUE_W-1:0] upper_value;
  } stbs_out_t;

  typedef struct packed {
    logic [CNT_W-1:0] entries_in_use;
    logic             allow_overrange;
  } stbs_cfg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FIRST,
    ST_LAST,
    ST_SEARCH
  } stbs_state_t;

endpackage

// ===== sv/stbs_ram.sv =====
// ----------------------------------------------------------------------------
// stbs_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module stbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/stbs_ctrl.sv =====
// ----------------------------------------------------------------------------
// stbs_ctrl
// Search sequencer: end checks on the first and last entry, then one halving
// step per memory read until the bracketing pair is left.
// ----------------------------------------------------------------------------
module stbs_ctrl
  import stbs_pkg::*;
#(
  parameter int TABLE_DEPTH = 64,
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
  localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  stbs_in_t           req,
  input  stbs_cfg_t          cfg,
  output logic               busy,
  output logic               done,
  output stbs_out_t          result,
  output logic               mem_we,
  output logic [AW-1:0]      mem_waddr,
  output logic [VALUE_W-1:0] mem_wdata,
  output logic [AW-1:0]      mem_raddr,
  input  logic [VALUE_W-1:0] mem_rdata
);

  stbs_state_t state, state_next;

  logic signed [VALUE_W-1:0] target, target_next;
  logic signed [VALUE_W-1:0] lo_val, lo_val_next;
  logic signed [VALUE_W-1:0] hi_val, hi_val_next;
  logic [AW-1:0]             lo, lo_next;
  logic [AW-1:0]             hi, hi_next;
  logic [AW-1:0]             mid, mid_next;
  logic [AW-1:0]             span;
  logic [AW-1:0]             last_idx;
  logic [31:0]               cnt_raw;
  logic [31:0]               cnt_clamped;
  logic [CW-1:0]             n_eff;
  logic                      n_ok;
  logic                      accept;
  logic                      cont;
  logic                      below_first;
  logic                      at_or_above_last;
  logic                      rd_le;
  logic                      done_next;
  stbs_out_t                 res, res_next;

  // clamp the entry count to the table depth
  assign cnt_raw     = 32'(cfg.entries_in_use);
  assign cnt_clamped = (cnt_raw > 32'(TABLE_DEPTH)) ? 32'(TABLE_DEPTH) : cnt_raw;
  assign n_eff       = cnt_clamped[CW-1:0];
  assign n_ok        = (cnt_clamped >= 32'd2);
  assign last_idx    = AW'(n_eff - CW'(1));

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  // during LAST, mem_rdata is the last entry and lo_val the first
  assign below_first      = (target < lo_val);
  assign at_or_above_last = !(target < $signed(mem_rdata));
  assign rd_le            = !(target < $signed(mem_rdata));

  // table writes happen only while idle, so reads never see a write in flight
  assign mem_we    = accept && (req.op == OP_WRITE)
                     && (32'(req.entry_index) < 32'(TABLE_DEPTH));
  assign mem_waddr = AW'(req.entry_index);
  assign mem_wdata = req.value;

  always_comb begin : next_state
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && req.op == OP_SEARCH && n_ok) begin
          state_next = ST_FIRST;
        end
      end
      ST_FIRST: begin
        state_next = ST_LAST;
      end
      ST_LAST: begin
        if (below_first || at_or_above_last || !cont) begin
          state_next = ST_IDLE;
        end else begin
          state_next = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (!cont) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // index range update and next midpoint
  always_comb begin : range_update
    lo_next     = lo;
    hi_next     = hi;
    lo_val_next = lo_val;
    hi_val_next = hi_val;
    target_next = target;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          target_next = req.value;
        end
      end
      ST_FIRST: begin
        lo_val_next = $signed(mem_rdata);
      end
      ST_LAST: begin
        hi_val_next = $signed(mem_rdata);
        lo_next     = '0;
        hi_next     = last_idx;
      end
      ST_SEARCH: begin
        if (rd_le) begin
          lo_next     = mid;
          lo_val_next = $signed(mem_rdata);
        end else begin
          hi_next     = mid;
          hi_val_next = $signed(mem_rdata);
        end
      end
      default: ;
    endcase
    span     = hi_next - lo_next;
    mid_next = lo_next + (span >> 1);
    cont     = (span > AW'(1));
  end

  always_comb begin : outputs
    done_next = 1'b0;
    res_next  = res;
    mem_raddr = mid_next;
    unique case (state)
      ST_IDLE: begin
        mem_raddr = '0;
        if (accept && req.op == OP_SEARCH && !n_ok) begin
          done_next = 1'b1;
          res_next  = '0;
        end
      end
      ST_FIRST: begin
        mem_raddr = last_idx;
      end
      ST_LAST: begin
        if (below_first) begin
          done_next = 1'b1;
          res_next  = '0;
          if (cfg.allow_overrange) begin
            res_next = '{found: 1'b1, lower_value: lo_val, upper_value: lo_val};
          end
        end else if (at_or_above_last) begin
          done_next = 1'b1;
          res_next  = '0;
          if (cfg.allow_overrange) begin
            res_next = '{found: 1'b1, lower_value: $signed(mem_rdata),
                         upper_value: $signed(mem_rdata)};
          end
        end else if (!cont) begin
          done_next = 1'b1;
          res_next  = '{found: 1'b1, lower_value: lo_val,
                        upper_value: $signed(mem_rdata)};
        end
      end
      ST_SEARCH: begin
        if (!cont) begin
          done_next = 1'b1;
          res_next  = '{found: 1'b1, lower_value: lo_val_next,
                        upper_value: hi_val_next};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
    target <= target_next;
    lo     <= lo_next;
    hi     <= hi_next;
    mid    <= mid_next;
    lo_val <= lo_val_next;
    hi_val <= hi_val_next;
    res    <= res_next;
  end

  assign result = res;

endmodule

// ===== sv/sorted_table_bracket_search_top.sv =====
// ----------------------------------------------------------------------------
// sorted_table_bracket_search_top
// Ascending Q16.16 breakpoint table in a RAM with a binary bracket search.
// ----------------------------------------------------------------------------
//  channel   signals                        handshake
//  -------   ----------------------------   ------------------------------
//  item in   start, busy, req               taken when start && !busy
//  result    done, result                   one-cycle strobe, no back-pressure
//  config    cfg_we, cfg_index, cfg_wdata   written when cfg_we is high
//
//  a write item leaves busy low and gives no result
//  a search with fewer than two entries gives its result in the next cycle
//  otherwise busy runs FIRST, LAST, then SEARCH until the bracketing pair is left (none on
//  an end hit or with two entries), one table read per cycle; the strobe comes in the first idle cycle
//  reset clears the sequencer state, the done strobe and the config registers; table contents are kept
//  the result strobe may overlap the acceptance of the next item
// ----------------------------------------------------------------------------
module sorted_table_bracket_search_top
  import stbs_pkg::*;
#(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  stbs_in_t             req,
  output logic                 done,
  output stbs_out_t            result,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  stbs_cfg_t          cfg;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [VALUE_W-1:0] mem_wdata;
  logic [AW-1:0]      mem_raddr;
  logic [VALUE_W-1:0] mem_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ENTRIES:   cfg.entries_in_use  <= cfg_wdata[CNT_W-1:0];
        REG_OVERRANGE: cfg.allow_overrange <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  stbs_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .req       (req),
    .cfg       (cfg),
    .busy      (busy),
    .done      (done),
    .result    (result),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  stbs_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

// ===== sv/stbs_checker.sv =====
// ----------------------------------------------------------------------------
// stbs_checker
// Port-level checks on item and result sequencing, bound to the top level.
// ----------------------------------------------------------------------------
module stbs_checker
  import stbs_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      start,
  input logic      busy,
  input stbs_in_t  req,
  input logic      done,
  input stbs_out_t result
);

  // a table write never produces a result
  a_write_silent: assert property (@(posedge clk) disable iff (rst)
    start && !busy && req.op == OP_WRITE |=> !done)
    else $error("result after a write item");

  // a result follows either an accepted item or a running search
  a_done_has_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(start) && !$past(busy)) || $past(busy))
    else $error("result with no item behind it");

  // a finished search always delivers its result
  a_search_ends_in_result: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) && !$past(rst) |-> done)
    else $error("search ended without a result");

  // failed searches carry zero values
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    done && !result.found |-> result.lower_value == '0 && result.upper_value == '0)
    else $error("failed result with nonzero values");

endmodule

bind sorted_table_bracket_search_top stbs_checker u_stbs_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .req    (req),
  .done   (done),
  .result (result)
);
